FILE: sv/leb_pkg.sv
// ---------------------------------------------------------------------------
// leb_pkg: shared types and constants of the line edit buffer
// Buffer geometry, field widths, command codes and the control word that
// is broadcast to every character cell.
// ---------------------------------------------------------------------------
`default_nettype none

package leb_pkg;

   // buffer geometry
   localparam int DEPTH  = 256;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int LEN_W  = IDX_W + 1;

   // field widths
   localparam int FUNC_W = 4;
   localparam int CP_W   = 21;

   // read tree: groups of cells selected in the first stage
   localparam int GRP_W  = IDX_W / 2;
   localparam int GRP_SZ = 1 << GRP_W;
   localparam int GRP_N  = DEPTH / GRP_SZ;
   localparam int SEL_W  = IDX_W - GRP_W;

   // smallest code point that counts as printable
   localparam logic [CP_W-1:0] PRINTABLE_MIN = CP_W'(32);

   // full capacity as a length value
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

   // command codes
   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT    = 4'd0,
      FN_LEFT      = 4'd1,
      FN_RIGHT     = 4'd2,
      FN_HOME      = 4'd3,
      FN_END       = 4'd4,
      FN_BACKSPACE = 4'd5,
      FN_DELETE    = 4'd6,
      FN_CLEAR     = 4'd7,
      FN_READ      = 4'd8
   } func_type;

   // what every cell does in a given cycle
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_ERASE  = 2'd2
   } cell_op_type;

   // control word broadcast along the chain
   typedef struct packed {
      cell_op_type       op;
      logic [IDX_W-1:0]  pos;
      logic [CP_W-1:0]   cp;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: sv/leb_cell.sv
// ---------------------------------------------------------------------------
// leb_cell: one character cell of the edit chain
// Holds one code point; on insert a cell past the caret takes its left neighbor
// and the cell at the caret the new character; on erase a cell at or past the erase point takes its right neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module leb_cell
   import leb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [IDX_W-1:0]  cell_idx,
   input  wire cell_ctl_type      ctl,
   input  wire logic [CP_W-1:0]   left_data,
   input  wire logic [CP_W-1:0]   right_data,
   output logic      [CP_W-1:0]   data
);

   logic [CP_W-1:0] data_ff;
   logic [CP_W-1:0] data_in;

   // next value from the broadcast op and this cell's place
   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (cell_idx > ctl.pos) begin
               data_in = left_data;
            end else if (cell_idx == ctl.pos) begin
               data_in = ctl.cp;
            end
         end
         OP_ERASE: begin
            if (cell_idx >= ctl.pos) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

FILE: sv/leb_read_tree.sv
// ---------------------------------------------------------------------------
// leb_read_tree: two-stage registered read select over the cell chain
// Stage one picks one cell in every group, stage two picks the group.
// ---------------------------------------------------------------------------
`default_nettype none

module leb_read_tree
   import leb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [CP_W-1:0]   cell_data [DEPTH],
   input  wire logic [IDX_W-1:0]  index,
   output logic      [CP_W-1:0]   read_data
);

   logic [CP_W-1:0]  grp_ff [GRP_N];
   logic [SEL_W-1:0] sel_ff;
   logic [CP_W-1:0]  data_ff;

   // stage one: one pick per group
   always_ff @(posedge clock) begin
      for (int g = 0; g < GRP_N; g++) begin
         grp_ff[g] <= cell_data[{SEL_W'(g), index[GRP_W-1:0]}];
      end
      sel_ff <= index[IDX_W-1:GRP_W];
   end

   // stage two: pick the group
   always_ff @(posedge clock) begin
      data_ff <= grp_ff[sel_ff];
   end

   assign read_data = data_ff;

endmodule

`default_nettype wire

FILE: sv/line_edit_buffer.sv
// ---------------------------------------------------------------------------
// line_edit_buffer: single-line text edit buffer with a caret
// A chain of character cells shifts the whole text in parallel on insert
// or erase; a small sequencer runs each command and reports one result.
// Timing: after the start transfer the sequencer runs execute, then read-tree
// gather, then registers the result strobe; a new command is accepted only
// once the sequencer is back in idle, as the read tree has two registered stages.
// Reset: synchronous; clears length, caret, limit and sequencer. Cell
// contents are not reset. The receiver cannot stall the result.
// ---------------------------------------------------------------------------
`default_nettype none

module line_edit_buffer
   import leb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [FUNC_W-1:0]  req_func,
   input  wire logic [CP_W-1:0]    req_code_point,
   input  wire logic [IDX_W-1:0]   req_read_index,
   // result channel
   output logic                    rsp_valid,
   output logic      [LEN_W-1:0]   rsp_caret_pos,
   output logic      [LEN_W-1:0]   rsp_text_length,
   output logic                    rsp_text_changed,
   output logic      [CP_W-1:0]    rsp_read_data,
   // configuration write
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [LEN_W-1:0]   csr_length_limit
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_GATHER = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  limit_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  car_ff, car_in;
   logic [FUNC_W-1:0] func_ff;
   logic [CP_W-1:0]   cp_ff;
   logic [IDX_W-1:0]  ridx_ff;
   logic              rsp_valid_ff;
   logic [LEN_W-1:0]  rsp_car_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic              rsp_chg_ff;
   logic              rsp_hit_ff;
   logic              chg_in;
   logic              hit_in;
   logic [LEN_W-1:0]  lim_eff;
   logic [LEN_W-1:0]  len_t;
   logic [LEN_W-1:0]  car_t;
   logic [LEN_W-1:0]  car_dec;
   cell_ctl_type      ctl;
   logic [CP_W-1:0]   cell_q [DEPTH];
   logic [CP_W-1:0]   tree_data;
   logic              req_xfer;

   assign busy      = (state_ff != ST_IDLE);
   assign req_xfer  = start && !busy;
   assign csr_ready = 1'b1;

   // effective limit, lowered-limit truncation and caret clamp
   always_comb begin
      lim_eff = limit_ff;
      if (limit_ff == '0 || limit_ff > DEPTH_LEN) begin
         lim_eff = DEPTH_LEN;
      end
      len_t   = (len_ff > lim_eff) ? lim_eff : len_ff;
      car_t   = (car_ff > len_t) ? len_t : car_ff;
      car_dec = car_t - LEN_W'(1);
   end

   // command decode
   always_comb begin
      len_in = len_t;
      car_in = car_t;
      chg_in = 1'b0;
      hit_in = 1'b0;
      ctl.op  = OP_HOLD;
      ctl.pos = car_t[IDX_W-1:0];
      ctl.cp  = cp_ff;
      case (func_ff)
         FN_INSERT: begin
            if (cp_ff >= PRINTABLE_MIN && len_t < lim_eff) begin
               ctl.op = OP_INSERT;
               len_in = len_t + LEN_W'(1);
               car_in = car_t + LEN_W'(1);
               chg_in = 1'b1;
            end
         end
         FN_LEFT: begin
            if (car_t != '0) begin
               car_in = car_dec;
            end
         end
         FN_RIGHT: begin
            if (car_t < len_t) begin
               car_in = car_t + LEN_W'(1);
            end
         end
         FN_HOME: car_in = '0;
         FN_END:  car_in = len_t;
         FN_BACKSPACE: begin
            if (car_t != '0) begin
               ctl.op  = OP_ERASE;
               ctl.pos = car_dec[IDX_W-1:0];
               car_in  = car_dec;
               len_in  = len_t - LEN_W'(1);
               chg_in  = 1'b1;
            end
         end
         FN_DELETE: begin
            if (car_t < len_t) begin
               ctl.op = OP_ERASE;
               len_in = len_t - LEN_W'(1);
               chg_in = 1'b1;
            end
         end
         FN_CLEAR: begin
            len_in = '0;
            car_in = '0;
            chg_in = 1'b1;
         end
         FN_READ: hit_in = ({1'b0, ridx_ff} < len_t);
         default: ;
      endcase
      if (state_ff != ST_EXEC) begin
         ctl.op = OP_HOLD;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_xfer) state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_GATHER;
         ST_GATHER: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= '0;
         len_ff       <= '0;
         car_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_GATHER);
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_length_limit;
         end
         if (state_ff == ST_EXEC) begin
            len_ff <= len_in;
            car_ff <= car_in;
         end
      end
   end

   // command and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff <= req_func;
         cp_ff   <= req_code_point;
         ridx_ff <= req_read_index;
      end
      if (state_ff == ST_EXEC) begin
         rsp_car_ff <= car_in;
         rsp_len_ff <= len_in;
         rsp_chg_ff <= chg_in;
         rsp_hit_ff <= hit_in;
      end
   end

   // chain of character cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [CP_W-1:0] left_d;
      logic [CP_W-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_q[i+1];
      end
      leb_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_W'(i)),
         .ctl        (ctl),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_q[i])
      );
   end

   // registered read select
   leb_read_tree u_read_tree (
      .clock     (clock),
      .cell_data (cell_q),
      .index     (ridx_ff),
      .read_data (tree_data)
   );

   // result ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_caret_pos    = rsp_car_ff;
   assign rsp_text_length  = rsp_len_ff;
   assign rsp_text_changed = rsp_chg_ff;
   assign rsp_read_data    = rsp_hit_ff ? tree_data : '0;

endmodule

`default_nettype wire

FILE: tb/line_edit_buffer_test.sv
// ---------------------------------------------------------------------------
// line_edit_buffer_test: self-checking bench for the line edit buffer
// Sends editing commands through the start/busy port and changes the
// length limit between phases. A tracker class keeps its own copy of the
// text, length, caret and limit and predicts every result. Each strobed
// result is compared field by field with the oldest prediction. A short
// directed run covers the edge cases, then an insert-heavy random phase
// fills the buffer deep before the limit is changed for the later phases.
// ---------------------------------------------------------------------------
module line_edit_buffer_test;
   import leb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SHOWN_ERRORS = 10;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd9;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;
   localparam logic [CP_W-1:0] CP_MAX = CP_W'(21'h10FFFF);
   localparam logic [CP_W-1:0] ASCII_MAX = CP_W'(126);

   // one result as seen on the rsp_ ports
   typedef struct packed {
      logic [LEN_W-1:0] caret_pos;
      logic [LEN_W-1:0] text_length;
      logic             text_changed;
      logic [CP_W-1:0]  read_data;
   } edit_result_type;

   // tracks the edit state and the results still owed by the block
   class line_edit_tracker;
      logic [CP_W-1:0]  cells[DEPTH];
      int unsigned      text_len;
      int unsigned      caret;
      logic [LEN_W-1:0] limit_reg;
      edit_result_type  owed_results[$];
      int               errors;

      function new();
         foreach (cells[i]) cells[i] = '0;
         text_len = 0;
         caret = 0;
         limit_reg = '0;
         errors = 0;
      endfunction

      function void set_limit(logic [LEN_W-1:0] value);
         limit_reg = value;
      endfunction

      function int unsigned active_limit();
         if (limit_reg == 0 || limit_reg > DEPTH_LEN)
            return DEPTH;
         return limit_reg;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // close up the text over the character at pos
      function void erase_char(int unsigned pos);
         for (int unsigned i = pos; i + 1 < text_len; i++)
            cells[i] = cells[i + 1];
         text_len--;
      endfunction

      // apply one accepted command and queue its result
      function void note_command(logic [FUNC_W-1:0] fn, logic [CP_W-1:0] cp,
                                 logic [IDX_W-1:0] idx);
         int unsigned lim;
         edit_result_type res;
         lim = active_limit();
         res = '0;
         // a lowered limit cuts the text, then the caret follows
         if (text_len > lim) text_len = lim;
         if (caret > text_len) caret = text_len;
         case (fn)
            FN_INSERT: begin
               if (cp >= PRINTABLE_MIN && text_len < lim) begin
                  for (int unsigned i = text_len; i > caret; i--)
                     cells[i] = cells[i - 1];
                  cells[caret] = cp;
                  text_len++;
                  caret++;
                  res.text_changed = 1'b1;
               end
            end
            FN_LEFT: if (caret > 0) caret--;
            FN_RIGHT: if (caret < text_len) caret++;
            FN_HOME: caret = 0;
            FN_END: caret = text_len;
            FN_BACKSPACE: begin
               if (caret != 0) begin
                  caret--;
                  erase_char(caret);
                  res.text_changed = 1'b1;
               end
            end
            FN_DELETE: begin
               if (caret < text_len) begin
                  erase_char(caret);
                  res.text_changed = 1'b1;
               end
            end
            FN_CLEAR: begin
               text_len = 0;
               caret = 0;
               res.text_changed = 1'b1;
            end
            FN_READ: if (idx < text_len) res.read_data = cells[idx];
            default: ;
         endcase
         res.caret_pos = LEN_W'(caret);
         res.text_length = LEN_W'(text_len);
         owed_results.push_back(res);
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= SHOWN_ERRORS) $display("%s", msg);
      endfunction

      // compare one strobed result with the oldest prediction
      function void check_result(edit_result_type got);
         edit_result_type want;
         if (owed_results.size() == 0) begin
            report($sformatf("unexpected result: caret %0d len %0d chg %b data %h",
                             got.caret_pos, got.text_length, got.text_changed,
                             got.read_data));
            return;
         end
         want = owed_results.pop_front();
         if (got.caret_pos !== want.caret_pos || got.text_length !== want.text_length ||
             got.text_changed !== want.text_changed || got.read_data !== want.read_data)
            report($sformatf({"mismatch: expected caret %0d len %0d chg %b data %h,",
                              " got caret %0d len %0d chg %b data %h"},
                             want.caret_pos, want.text_length, want.text_changed,
                             want.read_data, got.caret_pos, got.text_length,
                             got.text_changed, got.read_data));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [FUNC_W-1:0] req_func;
   logic [CP_W-1:0] req_code_point;
   logic [IDX_W-1:0] req_read_index;
   logic rsp_valid;
   logic [LEN_W-1:0] rsp_caret_pos;
   logic [LEN_W-1:0] rsp_text_length;
   logic rsp_text_changed;
   logic [CP_W-1:0] rsp_read_data;
   logic csr_valid;
   logic csr_ready;
   logic [LEN_W-1:0] csr_length_limit;

   line_edit_tracker tracker = new();
   int cycle_count = 0;

   line_edit_buffer DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_code_point   (req_code_point),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_caret_pos    (rsp_caret_pos),
      .rsp_text_length  (rsp_text_length),
      .rsp_text_changed (rsp_text_changed),
      .rsp_read_data    (rsp_read_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_length_limit (csr_length_limit)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         tracker.check_result('{rsp_caret_pos, rsp_text_length, rsp_text_changed,
                                rsp_read_data});
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one command transfer
   task automatic send_cmd(logic [FUNC_W-1:0] fn, logic [CP_W-1:0] cp = '0,
                           logic [IDX_W-1:0] idx = '0);
      @(negedge clock);
      start <= 1'b1;
      req_func <= fn;
      req_code_point <= cp;
      req_read_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_command(fn, cp, idx);
   endtask

   // idle gap before a command, mostly short and now and then long
   task automatic idle_gap();
      int pick;
      int cycles;
      pick = $urandom_range(0, 99);
      if (pick < 55) cycles = 0;
      else if (pick < 90) cycles = $urandom_range(1, 3);
      else cycles = $urandom_range(8, 40);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // limit write, only once every owed result has come back
   task automatic write_length_limit(logic [LEN_W-1:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_length_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_limit(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random command mix; insert share set per phase
   function automatic logic [FUNC_W-1:0] pick_func(int insert_pct, bit clear_ok);
      int pick;
      if ($urandom_range(0, 99) < insert_pct) return FN_INSERT;
      pick = $urandom_range(0, 19);
      if (pick < 12) return FUNC_W'(pick / 2 + 1);
      if (pick == 12) return clear_ok ? FN_CLEAR : FN_HOME;
      if (pick < 18) return FN_READ;
      return FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
   endfunction

   // mostly printable text, a few control characters
   function automatic logic [CP_W-1:0] pick_code_point();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) return CP_W'($urandom_range(0, PRINTABLE_MIN - 1));
      if (pick < 40) return CP_W'($urandom_range(PRINTABLE_MIN, ASCII_MAX));
      return CP_W'($urandom_range(PRINTABLE_MIN, CP_MAX));
   endfunction

   // reads land mostly inside the text
   function automatic logic [IDX_W-1:0] pick_read_index();
      if (tracker.text_len > 0 && $urandom_range(0, 3) != 0)
         return IDX_W'($urandom_range(0, tracker.text_len - 1));
      return IDX_W'($urandom());
   endfunction

   task automatic run_phase(int count, int insert_pct, bit clear_ok);
      for (int n = 0; n < count; n++) begin
         idle_gap();
         send_cmd(pick_func(insert_pct, clear_ok), pick_code_point(),
                  pick_read_index());
      end
   endtask

   // stimulus
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_func = FN_INSERT;
      req_code_point = '0;
      req_read_index = '0;
      csr_valid = 1'b0;
      csr_length_limit = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty text, control characters, caret at both edges
      write_length_limit('0);
      send_cmd(FN_CLEAR);
      send_cmd(FN_LEFT);
      send_cmd(FN_BACKSPACE);
      send_cmd(FN_DELETE);
      send_cmd(FN_INSERT, '0);
      send_cmd(FN_INSERT, PRINTABLE_MIN - 1);
      send_cmd(FN_INSERT, PRINTABLE_MIN);
      send_cmd(FN_INSERT, CP_MAX);
      send_cmd(FN_INSERT, CP_W'(65));
      send_cmd(FN_RIGHT);
      send_cmd(FN_HOME);
      send_cmd(FN_INSERT, CP_W'(21'h0FFFFF));
      send_cmd(FN_END);
      send_cmd(FN_LEFT);
      send_cmd(FN_DELETE);
      send_cmd(FN_BACKSPACE);
      send_cmd(FN_READ, '0, IDX_W'(0));
      send_cmd(FN_READ, '0, IDX_W'(1));
      send_cmd(FN_READ, '0, '1);
      send_cmd(FN_UNUSED_LO, CP_MAX, '1);
      send_cmd(FN_UNUSED_HI, CP_MAX, '1);

      // directed: full buffer, then a lowered limit
      write_length_limit(LEN_W'(3));
      send_cmd(FN_INSERT, ASCII_MAX);
      send_cmd(FN_INSERT, PRINTABLE_MIN);
      write_length_limit(LEN_W'(1));
      send_cmd(FN_READ, '0, IDX_W'(0));

      // random: fill deep at full capacity, then other limits
      write_length_limit(DEPTH_LEN);
      run_phase(260, 85, 1'b0);
      write_length_limit(LEN_W'(7));
      run_phase(40, 50, 1'b1);
      write_length_limit(LEN_W'(1));
      run_phase(25, 50, 1'b1);
      write_length_limit('0);
      run_phase(30, 45, 1'b1);
      write_length_limit(LEN_W'(255));
      run_phase(25, 45, 1'b1);
      write_length_limit(LEN_W'($urandom_range(2, 40)));
      run_phase(25, 50, 1'b1);

      // drain and report
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
